/* sv/mst_pkg.sv */
// ----------------------------------------------------------------------------
// mst_pkg
// Types and event codes shared by the multitouch slot tracker modules.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam logic [4:0] TYPE_SYN = 5'd0;
  localparam logic [4:0] TYPE_KEY = 5'd1;
  localparam logic [4:0] TYPE_ABS = 5'd3;

  localparam logic [9:0] CODE_REPORT    = 10'd0;
  localparam logic [9:0] CODE_SLOT      = 10'd47;
  localparam logic [9:0] CODE_POS_X     = 10'd53;
  localparam logic [9:0] CODE_POS_Y     = 10'd54;
  localparam logic [9:0] CODE_TRACK_ID  = 10'd57;
  localparam logic [9:0] CODE_TOUCH_BTN = 10'd330;

  typedef struct packed {
    logic [4:0]         event_type;
    logic [9:0]         event_code;
    logic signed [31:0] event_value;
  } event_t;

  typedef struct packed {
    logic               point_present;
    logic signed [31:0] point_tracking_id;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [3:0]         active_count;
    logic               last_of_report;
  } point_t;

  typedef struct packed {
    logic [31:0] touch_id;
    logic [31:0] x_position;
    logic [31:0] y_position;
  } slot_entry_t;

  localparam slot_entry_t ENTRY_RESET = '{
    touch_id:    32'hFFFF_FFFF,
    x_position:  32'd0,
    y_position:  32'd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EMPTY,
    ST_SCAN,
    ST_LOAD
  } state_t;

endpackage

/* sv/mst_ram.sv */
// ----------------------------------------------------------------------------
// mst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mst_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 10
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/multitouch_slot_tracker.sv */
// ----------------------------------------------------------------------------
// multitouch_slot_tracker
// Tracks touch slots from raw input events and reports the active contacts.
// ----------------------------------------------------------------------------
// Slot select, touch release and ignored beats are handled in ST_IDLE; id and
// position beats go on to ST_MERGE for the read, merge and write back of the
// slot RAM entry. An empty report passes through ST_EMPTY; any other scans the
// slots in ST_SCAN up to the last active one and emits each active slot from
// ST_LOAD; a stalled waiting result holds the report there. Synchronous active-low
// reset clears the slot controls and the written marks; the RAM is not cleared.
// ----------------------------------------------------------------------------
module multitouch_slot_tracker #(
  parameter int MAX_POINTS = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mst_pkg::event_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output mst_pkg::point_t out_data
);

  localparam int SW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = $bits(mst_pkg::slot_entry_t);

  mst_pkg::state_t      state_r, state_nxt;
  logic [SW-1:0]        sel_r, sel_nxt;
  logic [SW-1:0]        ptr_r, ptr_nxt;
  logic [MAX_POINTS-1:0] active_r, active_nxt;
  logic [MAX_POINTS-1:0] written_r, written_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        emit_r, emit_nxt;
  logic [9:0]           pend_code_r, pend_code_nxt;
  logic [31:0]          pend_val_r, pend_val_nxt;
  logic                 out_valid_r, out_valid_nxt;
  mst_pkg::point_t      out_data_r, out_data_nxt;

  logic                 ram_wr_en;
  logic [SW-1:0]        ram_wr_addr;
  mst_pkg::slot_entry_t ram_wr_data;
  logic                 ram_rd_en;
  logic [SW-1:0]        ram_rd_addr;
  logic [EW-1:0]        ram_rd_data;

  mst_pkg::slot_entry_t merge_base;
  mst_pkg::slot_entry_t load_base;
  logic                 out_free;
  logic                 val_neg;
  logic                 old_active;
  logic                 is_last;
  logic [31:0]          cnt_ext;

  mst_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_POINTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_stall  = (state_r != mst_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_free   = !out_valid_r || !out_stall;
  assign val_neg    = in_data.event_value[31];
  assign old_active = active_r[sel_r];
  assign is_last    = (CW'(emit_r + 1'b1) == cnt_r);
  assign cnt_ext    = 32'(cnt_r);

  assign merge_base = written_r[sel_r] ? mst_pkg::slot_entry_t'(ram_rd_data)
                                       : mst_pkg::ENTRY_RESET;
  assign load_base  = written_r[ptr_r] ? mst_pkg::slot_entry_t'(ram_rd_data)
                                       : mst_pkg::ENTRY_RESET;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mst_pkg::ST_IDLE;
      sel_r       <= '0;
      ptr_r       <= '0;
      active_r    <= '0;
      written_r   <= '0;
      cnt_r       <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      ptr_r       <= ptr_nxt;
      active_r    <= active_nxt;
      written_r   <= written_nxt;
      cnt_r       <= cnt_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_code_r <= pend_code_nxt;
    pend_val_r  <= pend_val_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    ptr_nxt       = ptr_r;
    active_nxt    = active_r;
    written_nxt   = written_r;
    cnt_nxt       = cnt_r;
    emit_nxt      = emit_r;
    pend_code_nxt = pend_code_r;
    pend_val_nxt  = pend_val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = sel_r;
    ram_wr_data   = merge_base;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = sel_r;

    case (pend_code_r)
      mst_pkg::CODE_TRACK_ID: ram_wr_data.touch_id   = pend_val_r;
      mst_pkg::CODE_POS_X:    ram_wr_data.x_position = pend_val_r;
      default:                ram_wr_data.y_position = pend_val_r;
    endcase

    unique case (state_r)
      mst_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.event_type == mst_pkg::TYPE_ABS) begin
            if (in_data.event_code == mst_pkg::CODE_SLOT) begin
              if (!val_neg && (unsigned'(in_data.event_value) < 32'(MAX_POINTS))) begin
                sel_nxt = in_data.event_value[SW-1:0];
              end else begin
                sel_nxt = '0;
              end
            end else if (in_data.event_code == mst_pkg::CODE_TRACK_ID ||
                         in_data.event_code == mst_pkg::CODE_POS_X ||
                         in_data.event_code == mst_pkg::CODE_POS_Y) begin
              ram_rd_en     = 1'b1;
              pend_code_nxt = in_data.event_code;
              pend_val_nxt  = in_data.event_value;
              state_nxt     = mst_pkg::ST_MERGE;
              if (in_data.event_code == mst_pkg::CODE_TRACK_ID) begin
                active_nxt[sel_r] = !val_neg;
                if (old_active && val_neg) begin
                  cnt_nxt = CW'(cnt_r - 1'b1);
                end else if (!old_active && !val_neg) begin
                  cnt_nxt = CW'(cnt_r + 1'b1);
                end
              end
            end
          end else if (in_data.event_type == mst_pkg::TYPE_KEY &&
                       in_data.event_code == mst_pkg::CODE_TOUCH_BTN &&
                       in_data.event_value == 32'sd0) begin
            active_nxt = '0;
            cnt_nxt    = '0;
          end else if (in_data.event_type == mst_pkg::TYPE_SYN &&
                       in_data.event_code == mst_pkg::CODE_REPORT) begin
            emit_nxt  = '0;
            ptr_nxt   = '0;
            state_nxt = (cnt_r == '0) ? mst_pkg::ST_EMPTY : mst_pkg::ST_SCAN;
          end
        end
      end
      mst_pkg::ST_MERGE: begin
        ram_wr_en          = 1'b1;
        written_nxt[sel_r] = 1'b1;
        state_nxt          = mst_pkg::ST_IDLE;
      end
      mst_pkg::ST_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{
            point_present:     1'b0,
            point_tracking_id: 32'sd0,
            point_x:           32'sd0,
            point_y:           32'sd0,
            active_count:      4'd0,
            last_of_report:    1'b1
          };
          state_nxt     = mst_pkg::ST_IDLE;
        end
      end
      mst_pkg::ST_SCAN: begin
        ram_rd_addr = ptr_r;
        if (active_r[ptr_r]) begin
          ram_rd_en = 1'b1;
          state_nxt = mst_pkg::ST_LOAD;
        end else begin
          ptr_nxt = SW'(ptr_r + 1'b1);
        end
      end
      mst_pkg::ST_LOAD: begin
        ram_rd_addr = ptr_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{
            point_present:     1'b1,
            point_tracking_id: load_base.touch_id,
            point_x:           load_base.x_position,
            point_y:           load_base.y_position,
            active_count:      cnt_ext[3:0],
            last_of_report:    is_last
          };
          emit_nxt      = CW'(emit_r + 1'b1);
          ptr_nxt       = SW'(ptr_r + 1'b1);
          state_nxt     = is_last ? mst_pkg::ST_IDLE : mst_pkg::ST_SCAN;
        end
      end
      default: begin
        state_nxt = mst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* tb/touch_report_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_report_checker
// Watches both channels of the multitouch slot tracker. It keeps its own copy
// of the touch slot table, computes the points that each report should emit,
// and compares every accepted result with the oldest pending point.
// ----------------------------------------------------------------------------
module touch_report_checker #(
  parameter int MAX_POINTS = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  mst_pkg::event_t in_data,
  input  logic            out_valid,
  input  logic            out_stall,
  input  mst_pkg::point_t out_data,
  output int              fail_count,
  output int              pending_count
);

  int              cur_slot;
  logic [31:0]     slot_id [MAX_POINTS];
  logic            slot_on [MAX_POINTS];
  logic [31:0]     slot_x [MAX_POINTS];
  logic [31:0]     slot_y [MAX_POINTS];
  mst_pkg::point_t expected_points [$];
  mst_pkg::point_t want_point;

  task automatic clear_slots();
    cur_slot = 0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      slot_id[i] = '1;
      slot_on[i] = 1'b0;
      slot_x[i]  = '0;
      slot_y[i]  = '0;
    end
  endtask

  task automatic track_event(input mst_pkg::event_t ev);
    int              s;
    int              live;
    int              k;
    mst_pkg::point_t pt;
    s = cur_slot;
    if (ev.event_type == mst_pkg::TYPE_ABS) begin
      case (ev.event_code)
        mst_pkg::CODE_SLOT: begin
          if (!ev.event_value[31] && ev.event_value[30:0] < MAX_POINTS) begin
            cur_slot = int'(ev.event_value[30:0]);
          end else begin
            cur_slot = 0;
          end
        end
        mst_pkg::CODE_TRACK_ID: begin
          slot_id[s] = ev.event_value;
          slot_on[s] = !ev.event_value[31];
        end
        mst_pkg::CODE_POS_X: slot_x[s] = ev.event_value;
        mst_pkg::CODE_POS_Y: slot_y[s] = ev.event_value;
        default: ;
      endcase
    end else if (ev.event_type == mst_pkg::TYPE_KEY &&
                 ev.event_code == mst_pkg::CODE_TOUCH_BTN &&
                 ev.event_value == 0) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        slot_on[i] = 1'b0;
      end
    end else if (ev.event_type == mst_pkg::TYPE_SYN &&
                 ev.event_code == mst_pkg::CODE_REPORT) begin
      live = 0;
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (slot_on[i]) begin
          live++;
        end
      end
      if (live == 0) begin
        pt = '0;
        pt.last_of_report = 1'b1;
        expected_points.push_back(pt);
      end else begin
        k = 0;
        for (int i = 0; i < MAX_POINTS; i++) begin
          if (slot_on[i]) begin
            pt.point_present     = 1'b1;
            pt.point_tracking_id = slot_id[i];
            pt.point_x           = slot_x[i];
            pt.point_y           = slot_y[i];
            pt.active_count      = 4'(live);
            pt.last_of_report    = (k == live - 1);
            expected_points.push_back(pt);
            k++;
          end
        end
      end
    end
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_slots();
      expected_points.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: result beat with nothing pending, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want_point = expected_points.pop_front();
          compare_field("point_present", 32'(want_point.point_present),
                        32'(out_data.point_present));
          compare_field("point_tracking_id", want_point.point_tracking_id,
                        out_data.point_tracking_id);
          compare_field("point_x", want_point.point_x, out_data.point_x);
          compare_field("point_y", want_point.point_y, out_data.point_y);
          compare_field("active_count", 32'(want_point.active_count),
                        32'(out_data.active_count));
          compare_field("last_of_report", 32'(want_point.last_of_report),
                        32'(out_data.last_of_report));
        end
      end
      if (in_valid && !in_stall) begin
        track_event(in_data);
      end
    end
    pending_count <= expected_points.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw touch events into the multitouch slot tracker: a directed set of
// corner cases first, then random touch frames, full-table frames, releases
// and noise, with random gaps on the event side, random stalls on the result
// side and one long hold there. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_POINTS = 10;
  localparam int NUM_ITEMS  = 450;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  mst_pkg::event_t in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  mst_pkg::point_t out_data;

  int fail_count;
  int pending_count;
  int items_sent    = 0;
  bit pressure_req  = 1'b0;
  bit sender_calm   = 1'b0;

  multitouch_slot_tracker #(
    .MAX_POINTS(MAX_POINTS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  touch_report_checker #(
    .MAX_POINTS(MAX_POINTS)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic mst_pkg::event_t make_event(input logic [4:0] ev_type,
                                                 input logic [9:0] ev_code,
                                                 input logic [31:0] ev_value);
    mst_pkg::event_t ev;
    ev.event_type  = ev_type;
    ev.event_code  = ev_code;
    ev.event_value = ev_value;
    return ev;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_hold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0;
      4, 5, 6: return $urandom_range(0, 4095);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_track_id();
    case ($urandom_range(0, 11))
      0:       return 32'hFFFF_FFFF;
      1, 2:    return $urandom | 32'h8000_0000;
      3, 4:    return $urandom & 32'h7FFF_FFFF;
      default: return $urandom_range(0, 2000);
    endcase
  endfunction

  function automatic logic [31:0] pick_slot();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return $urandom_range(0, MAX_POINTS - 1);
    if (r == 16) return $urandom_range(MAX_POINTS, 15);
    if (r == 17) return $urandom & 32'h7FFF_FFFF;
    return $urandom | 32'h8000_0000;
  endfunction

  task automatic send_beat(input mst_pkg::event_t ev);
    int  gap;
    bit  stalled;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    items_sent++;
  endtask

  task automatic send_report();
    send_beat(make_event(mst_pkg::TYPE_SYN, mst_pkg::CODE_REPORT, pick_value()));
  endtask

  task automatic send_touch_frame();
    int n;
    n = $urandom_range(1, 5);
    repeat (n) begin
      if ($urandom_range(0, 3) != 0) begin
        send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, pick_slot()));
      end
      case ($urandom_range(0, 3))
        0: send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TRACK_ID, pick_track_id()));
        1: send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_POS_X, pick_value()));
        2: send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_POS_Y, pick_value()));
        default: begin
          send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TRACK_ID, pick_track_id()));
          send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_POS_X, pick_value()));
          send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_POS_Y, pick_value()));
        end
      endcase
    end
    if ($urandom_range(0, 19) == 0) begin
      send_beat(make_event(mst_pkg::TYPE_KEY, mst_pkg::CODE_TOUCH_BTN,
                           $urandom_range(0, 1)));
    end
    if ($urandom_range(0, 99) < 85) begin
      send_report();
    end
  endtask

  task automatic send_full_frame();
    for (int s = 0; s < MAX_POINTS; s++) begin
      send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, s));
      send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TRACK_ID,
                           $urandom_range(0, 2000)));
      if ($urandom_range(0, 1) == 0) begin
        send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_POS_X, pick_value()));
      end
    end
    send_report();
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_beat(make_event(5'($urandom), 10'($urandom), $urandom));
      1: send_beat(make_event(mst_pkg::TYPE_ABS, 10'($urandom), pick_value()));
      2: send_beat(make_event(mst_pkg::TYPE_KEY, 10'($urandom), pick_value()));
      default: send_beat(make_event(mst_pkg::TYPE_SYN, 10'($urandom), pick_value()));
    endcase
  endtask

  // Result side: random holds, calm stretches, and one long hold on request.
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (pressure_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        pressure_req = 1'b0;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 2) begin
        out_stall <= 1'b0;
        repeat (80) @(posedge clk);
      end else begin
        hold = pick_hold();
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int r;
    bit pressure_done;
    pressure_done = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_report();
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, 32'd0));
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TRACK_ID, 32'd0));
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_POS_X, 32'h7FFF_FFFF));
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_POS_Y, 32'h8000_0000));
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, MAX_POINTS - 1));
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TRACK_ID, 32'h7FFF_FFFF));
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_POS_X, 32'hFFFF_FFFF));
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_POS_Y, 32'd0));
    send_report();
    send_beat(make_event(mst_pkg::TYPE_KEY, mst_pkg::CODE_TOUCH_BTN, 32'd1));
    send_report();
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, MAX_POINTS));
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_TRACK_ID, 32'hFFFF_FFFF));
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_POS_X, 32'd5));
    send_report();
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, 32'h8000_0000));
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, 32'h7FFF_FFFF));
    send_beat(make_event(5'h1F, 10'h3FF, 32'h0));
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_REPORT, 32'd7));
    send_beat(make_event(mst_pkg::TYPE_SYN, mst_pkg::CODE_SLOT, 32'd3));
    send_beat(make_event(mst_pkg::TYPE_KEY, mst_pkg::CODE_TOUCH_BTN, 32'h8000_0000));
    send_beat(make_event(mst_pkg::TYPE_ABS, mst_pkg::CODE_SLOT, 32'hFFFF_FFFF));
    send_beat(make_event(mst_pkg::TYPE_KEY, mst_pkg::CODE_TOUCH_BTN, 32'd0));
    send_report();

    while (items_sent < NUM_ITEMS) begin
      sender_calm = ($urandom_range(0, 9) == 0);
      if (!pressure_done && items_sent >= 200) begin
        pressure_done = 1'b1;
        pressure_req  = 1'b1;
        sender_calm   = 1'b1;
        send_full_frame();
        repeat (8) send_report();
      end
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_touch_frame();
      end else if (r < 78) begin
        send_full_frame();
      end else if (r < 88) begin
        send_beat(make_event(mst_pkg::TYPE_KEY, mst_pkg::CODE_TOUCH_BTN, 32'd0));
        send_report();
      end else begin
        send_noise();
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
